// File: rtl/assert_macros.svh
// Assertion macros for the color restoration RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define RCR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("color restoration assertion failed");
`define RCR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("color restoration assertion failed");
`else
`define RCR_ASSERT(lbl, clk, rst_n, prop)
`define RCR_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: rtl/rcr_pkg.sv
// Types, constants and tables of the color restoration block.
package rcr_pkg;

  localparam int MAX_BANDS   = 3;
  localparam int NUM_LANES   = 3;
  localparam int SAMPLE_BITS = 8;
  localparam int V_BITS      = SAMPLE_BITS + 1;
  localparam int GAIN_BITS   = 8;
  localparam int CNT_BITS    = 2;
  localparam int ARG_BITS    = GAIN_BITS + V_BITS + CNT_BITS;
  localparam int SUM_BITS    = V_BITS + CNT_BITS;
  localparam int LOG_P_BITS  = 5;
  localparam int LOG_BITS    = LOG_P_BITS + 16;
  localparam int LOG10_2_BITS = 15;
  localparam int BK_BITS     = GAIN_BITS + LOG10_2_BITS;
  localparam int PROD_BITS   = LOG_BITS + BK_BITS;
  localparam int OUT_BITS    = 20;
  localparam int SHIFT_BITS  = 24;
  localparam int NORM_PAD    = 32 - ARG_BITS;

  localparam logic [LOG10_2_BITS-1:0] LOG10_2_Q16 = 15'd19728;
  localparam logic [LOG_BITS-1:0] SAT_POS = 21'd524287;
  localparam logic [LOG_BITS-1:0] SAT_NEG = 21'd524288;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 8;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BAND_COUNT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN_ALPHA = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN_BETA  = 2'd2;

  localparam logic [CNT_BITS-1:0]  RST_BAND_COUNT = 2'd3;
  localparam logic [GAIN_BITS-1:0] RST_GAIN_ALPHA = 8'd128;
  localparam logic [GAIN_BITS-1:0] RST_GAIN_BETA  = 8'd46;

  localparam logic [16:0] LOG2_TAB [0:16] = '{
    17'd0,     17'd5732,  17'd11136, 17'd16248, 17'd21098, 17'd25711,
    17'd30109, 17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49472,
    17'd52911, 17'd56229, 17'd59434, 17'd62534, 17'd65536
  };

  typedef struct packed {
    logic adv1;
    logic adv2;
    logic adv3;
  } rcr_adv_t;

endpackage

// File: rtl/rcr_if.sv
// Valid/ready channel interfaces for pixels and restoration factors.
interface rcr_in_if;
  logic                               valid;
  logic                               ready;
  logic [rcr_pkg::SAMPLE_BITS-1:0]    band_first_sample;
  logic [rcr_pkg::SAMPLE_BITS-1:0]    band_second_sample;
  logic [rcr_pkg::SAMPLE_BITS-1:0]    band_third_sample;

  modport source (output valid, band_first_sample, band_second_sample,
                  band_third_sample, input ready);
  modport sink (input valid, band_first_sample, band_second_sample,
                band_third_sample, output ready);
endinterface

interface rcr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [rcr_pkg::OUT_BITS-1:0] factor_first;
  logic signed [rcr_pkg::OUT_BITS-1:0] factor_second;
  logic signed [rcr_pkg::OUT_BITS-1:0] factor_third;

  modport source (output valid, factor_first, factor_second, factor_third,
                  input ready);
  modport sink (input valid, factor_first, factor_second, factor_third,
                output ready);
endinterface

// File: rtl/retinex_color_restoration_core.sv
// Top level of the multi-scale-retinex color restoration factor block.
// Usage:
// One pixel of up to three 8-bit bands enters on in_px; one result item
// carrying three signed Q12.8 restoration factors leaves on out_px.
// Both channels transfer when valid and ready are high at a clock edge.
// The configuration port writes band_count (index 0), gain_alpha (index 1)
// and gain_beta (index 2) when cfg_we is high; write only while idle.
// Each band has its own lane; the shared log2 of the band sum runs beside
// them, and a merge register zeroes unused bands, or all bands when alpha
// is zero, and drives the output. A pixel passes the stage registers one to
// three and then that output register, which drives out_px.valid.
// Without a stall, throughput is one pixel per cycle (four-stage pipeline).
// When the receiver stalls, the output register holds and earlier stages
// keep filling until every stage is full; then in_px.ready goes low.
// A synchronous reset clears all valid bits and loads the register
// defaults: three bands, alpha 128, beta 46.
`include "assert_macros.svh"

module retinex_color_restoration_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [rcr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [rcr_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  rcr_in_if.sink                             in_px,
  rcr_out_if.source                          out_px
);

  logic [rcr_pkg::CNT_BITS-1:0]  cnt_r;
  logic [rcr_pkg::GAIN_BITS-1:0] alpha_r;
  logic [rcr_pkg::GAIN_BITS-1:0] beta_r;
  logic [rcr_pkg::BK_BITS-1:0]   beta_k_r;

  logic v1_r, v2_r, v3_r, ov_r;
  logic rdy1, rdy2, rdy3, rdy4;
  rcr_pkg::rcr_adv_t adv;

  logic [rcr_pkg::CNT_BITS-1:0]  n_eff;
  logic [rcr_pkg::V_BITS-1:0]    vals [rcr_pkg::NUM_LANES];
  logic [rcr_pkg::NUM_LANES-1:0] mask_nxt;
  logic [rcr_pkg::NUM_LANES-1:0] mask1_r, mask2_r, mask3_r;
  logic [rcr_pkg::SUM_BITS-1:0]  sum_nxt;
  logic [rcr_pkg::SUM_BITS-1:0]  sum_r;
  logic [rcr_pkg::LOG_BITS-1:0]  log_sum;
  logic [rcr_pkg::LOG_BITS-1:0]  ls_r;
  logic signed [rcr_pkg::OUT_BITS-1:0] fact [rcr_pkg::NUM_LANES];
  logic signed [rcr_pkg::OUT_BITS-1:0] out_fact_r [rcr_pkg::NUM_LANES];
  logic                          out_all_zero;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= rcr_pkg::RST_BAND_COUNT;
      alpha_r <= rcr_pkg::RST_GAIN_ALPHA;
      beta_r  <= rcr_pkg::RST_GAIN_BETA;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rcr_pkg::CFG_BAND_COUNT: cnt_r   <= cfg_wdata[rcr_pkg::CNT_BITS-1:0];
        rcr_pkg::CFG_GAIN_ALPHA: alpha_r <= cfg_wdata[rcr_pkg::GAIN_BITS-1:0];
        rcr_pkg::CFG_GAIN_BETA:  beta_r  <= cfg_wdata[rcr_pkg::GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    beta_k_r <= rcr_pkg::BK_BITS'(beta_r) * rcr_pkg::BK_BITS'(rcr_pkg::LOG10_2_Q16);
  end

  assign rdy4 = !ov_r || out_px.ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_px.ready = rdy1;
  assign adv = '{adv1: rdy1, adv2: rdy2, adv3: rdy3};

  always_comb begin
    n_eff = (32'(cnt_r) > rcr_pkg::MAX_BANDS) ? rcr_pkg::CNT_BITS'(rcr_pkg::MAX_BANDS) : cnt_r;
    vals[0] = rcr_pkg::V_BITS'(in_px.band_first_sample) + rcr_pkg::V_BITS'(1);
    vals[1] = rcr_pkg::V_BITS'(in_px.band_second_sample) + rcr_pkg::V_BITS'(1);
    vals[2] = rcr_pkg::V_BITS'(in_px.band_third_sample) + rcr_pkg::V_BITS'(1);
    sum_nxt = '0;
    for (int b = 0; b < rcr_pkg::NUM_LANES; b++) begin
      mask_nxt[b] = (b < 32'(n_eff)) && (alpha_r != '0);
      if (b < 32'(n_eff)) begin
        sum_nxt = sum_nxt + rcr_pkg::SUM_BITS'(vals[b]);
      end
    end
  end

  rcr_log2 u_sum_log (.x(rcr_pkg::ARG_BITS'(sum_r)), .y(log_sum));

  for (genvar b = 0; b < rcr_pkg::NUM_LANES; b++) begin : g_lane
    rcr_lane u_lane (
      .clk     (clk),
      .adv     (adv),
      .v       (vals[b]),
      .alpha   (alpha_r),
      .n       (n_eff),
      .log_sum (ls_r),
      .beta_k  (beta_k_r),
      .factor  (fact[b])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_px.valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        ov_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      sum_r   <= sum_nxt;
      mask1_r <= mask_nxt;
    end
    if (rdy2) begin
      ls_r    <= log_sum;
      mask2_r <= mask1_r;
    end
    if (rdy3) begin
      mask3_r <= mask2_r;
    end
    if (rdy4) begin
      for (int b = 0; b < rcr_pkg::NUM_LANES; b++) begin
        out_fact_r[b] <= mask3_r[b] ? fact[b] : '0;
      end
    end
  end

  assign out_px.valid         = ov_r;
  assign out_px.factor_first  = out_fact_r[0];
  assign out_px.factor_second = out_fact_r[1];
  assign out_px.factor_third  = out_fact_r[2];

  assign out_all_zero = (out_fact_r[0] == '0) && (out_fact_r[1] == '0) &&
                        (out_fact_r[2] == '0);

  `RCR_ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_px.valid)
  `RCR_ASSERT(a_full_blocks_input, clk, rst_n, (v1_r && v2_r && v3_r && !rdy4) |-> !in_px.ready)
  `RCR_ASSERT(a_unused_third_zero, clk, rst_n, (ov_r && (cnt_r < 2'd3)) |-> (out_fact_r[2] == '0))
  `RCR_ASSERT(a_zero_alpha_zero, clk, rst_n, (ov_r && (alpha_r == '0)) |-> out_all_zero)

endmodule

// File: rtl/rcr_log2.sv
// Fixed-point Q.16 log2 from leading-one position and interpolated table.
module rcr_log2 (
  input  logic [rcr_pkg::ARG_BITS-1:0] x,
  output logic [rcr_pkg::LOG_BITS-1:0] y
);

  logic [rcr_pkg::LOG_P_BITS-1:0] pos;
  logic [rcr_pkg::LOG_P_BITS-1:0] shamt;
  logic [rcr_pkg::ARG_BITS-1:0]   shifted;
  logic [31:0]                    norm;
  logic [3:0]                     idx;
  logic [15:0]                    rem;
  logic [16:0]                    lo;
  logic [16:0]                    hi;
  logic [16:0]                    diff;
  logic [32:0]                    interp;

  always_comb begin
    pos = '0;
    for (int i = 0; i < rcr_pkg::ARG_BITS; i++) begin
      if (x[i]) begin
        pos = rcr_pkg::LOG_P_BITS'(i);
      end
    end
    shamt   = rcr_pkg::LOG_P_BITS'(rcr_pkg::ARG_BITS - 1) - pos;
    shifted = x << shamt;
    norm    = {shifted, {rcr_pkg::NORM_PAD{1'b0}}};
    idx     = norm[30:27];
    rem     = norm[26:11];
    lo      = rcr_pkg::LOG2_TAB[idx];
    hi      = rcr_pkg::LOG2_TAB[5'(idx) + 5'd1];
    diff    = hi - lo;
    interp  = 33'(diff) * 33'(rem);
    y       = {pos, 16'd0} + rcr_pkg::LOG_BITS'(lo) + rcr_pkg::LOG_BITS'(interp[32:16]);
  end

endmodule

// File: rtl/rcr_lane.sv
// One band lane: log argument, log2, scaled difference, rounding and saturation.
module rcr_lane (
  input  logic                                clk,
  input  rcr_pkg::rcr_adv_t                   adv,
  input  logic [rcr_pkg::V_BITS-1:0]          v,
  input  logic [rcr_pkg::GAIN_BITS-1:0]       alpha,
  input  logic [rcr_pkg::CNT_BITS-1:0]        n,
  input  logic [rcr_pkg::LOG_BITS-1:0]        log_sum,
  input  logic [rcr_pkg::BK_BITS-1:0]         beta_k,
  output logic signed [rcr_pkg::OUT_BITS-1:0] factor
);

  logic [rcr_pkg::GAIN_BITS+rcr_pkg::V_BITS-1:0] av;
  logic [rcr_pkg::ARG_BITS-1:0]  arg_nxt;
  logic [rcr_pkg::ARG_BITS-1:0]  arg_r;
  logic [rcr_pkg::LOG_BITS-1:0]  log_arg;
  logic [rcr_pkg::LOG_BITS-1:0]  la_r;
  logic signed [rcr_pkg::LOG_BITS:0] d;
  logic [rcr_pkg::LOG_BITS-1:0]  mag;
  logic [rcr_pkg::PROD_BITS-1:0] prod_nxt;
  logic [rcr_pkg::PROD_BITS-1:0] prod_r;
  logic                          neg_r;
  logic [rcr_pkg::PROD_BITS:0]   rnd;
  logic [rcr_pkg::LOG_BITS-1:0]  q;
  logic [rcr_pkg::LOG_BITS-1:0]  sat;

  always_comb begin
    av = (rcr_pkg::GAIN_BITS + rcr_pkg::V_BITS)'(alpha) *
         (rcr_pkg::GAIN_BITS + rcr_pkg::V_BITS)'(v);
    unique case (n)
      2'd0:    arg_nxt = '0;
      2'd1:    arg_nxt = rcr_pkg::ARG_BITS'(av);
      2'd2:    arg_nxt = rcr_pkg::ARG_BITS'(av) << 1;
      default: arg_nxt = rcr_pkg::ARG_BITS'(av) + (rcr_pkg::ARG_BITS'(av) << 1);
    endcase
  end

  rcr_log2 u_log (.x(arg_r), .y(log_arg));

  always_comb begin
    d        = $signed({1'b0, la_r}) - $signed({1'b0, log_sum});
    mag      = d[rcr_pkg::LOG_BITS] ? rcr_pkg::LOG_BITS'(-d) : d[rcr_pkg::LOG_BITS-1:0];
    prod_nxt = rcr_pkg::PROD_BITS'(mag) * rcr_pkg::PROD_BITS'(beta_k);
  end

  always_ff @(posedge clk) begin
    if (adv.adv1) begin
      arg_r <= arg_nxt;
    end
    if (adv.adv2) begin
      la_r <= log_arg;
    end
    if (adv.adv3) begin
      prod_r <= prod_nxt;
      neg_r  <= d[rcr_pkg::LOG_BITS];
    end
  end

  always_comb begin
    rnd = {1'b0, prod_r} + ((rcr_pkg::PROD_BITS + 1)'(1) << (rcr_pkg::SHIFT_BITS - 1));
    q   = rcr_pkg::LOG_BITS'(rnd >> rcr_pkg::SHIFT_BITS);
    if (neg_r) begin
      sat = (q > rcr_pkg::SAT_NEG) ? rcr_pkg::SAT_NEG : q;
      factor = rcr_pkg::OUT_BITS'(-sat);
    end else begin
      sat = (q > rcr_pkg::SAT_POS) ? rcr_pkg::SAT_POS : q;
      factor = rcr_pkg::OUT_BITS'(sat);
    end
  end

endmodule
